### hw/rtl/pmt_hit_calibrator_unit_macros.svh
// assertion macros for the pmt hit calibrator unit
// expects clk_i and rst_ni in the module that uses them
`ifndef PMT_HIT_CALIBRATOR_UNIT_MACROS_SVH
`define PMT_HIT_CALIBRATOR_UNIT_MACROS_SVH

// same-cycle implication
`define PMTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PMTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/pmtc_pkg.sv
// types, constants and helpers of the pmt hit calibrator
// no dependencies
package pmtc_pkg;

  localparam int CH_W   = 10;
  localparam int ADC_W  = 12;
  localparam int TDC_W  = 12;
  localparam int SM_W   = 16;
  localparam int WORD_W = 32;

  // step counts of the iterative units
  localparam int SQ_STEPS   = 24;
  localparam int NPE_STEPS  = 40;
  localparam int TDIV_STEPS = 48;

  // hit pipe: input registers to registered time
  localparam int HIT_LAT  = 3 + SQ_STEPS + TDIV_STEPS;
  localparam int NPE_PAD  = HIT_LAT - NPE_STEPS - 2;
  // accept edge to the edge that samples done
  localparam int UNIT_LAT = HIT_LAT + 2;

  localparam logic [SM_W-1:0] SIGMA_MULT_RST = 16'd768;
  localparam logic signed [WORD_W-1:0] GAIN_LIMIT    = 32'sd65536000;
  localparam logic signed [WORD_W-1:0] TIME_SENTINEL = -32'sd2559744;

  typedef enum logic {
    OP_CALIBRATE = 1'b0,
    OP_WRITE     = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    KIND_ADC_PED   = 3'd0,
    KIND_ADC_GAIN  = 3'd1,
    KIND_TDC_PED   = 3'd2,
    KIND_TDC_SIGMA = 3'd3,
    KIND_TDC_GAIN  = 3'd4,
    KIND_SLEW0     = 3'd5,
    KIND_SLEW1     = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_CALIBRATED = 2'd0,
    ST_WRITTEN    = 2'd1,
    ST_RANGE      = 2'd2
  } status_e;

  typedef struct packed {
    logic                     operation;
    logic [CH_W-1:0]          channel_a;
    logic [ADC_W-1:0]         adc_a;
    logic [TDC_W-1:0]         tdc_a;
    logic [CH_W-1:0]          channel_b;
    logic [ADC_W-1:0]         adc_b;
    logic [TDC_W-1:0]         tdc_b;
    logic [2:0]               param_kind;
    logic signed [WORD_W-1:0] param_value;
  } pmtc_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] npe_a;
    logic signed [WORD_W-1:0] npe_b;
    logic signed [WORD_W-1:0] time_a;
    logic signed [WORD_W-1:0] time_b;
    logic signed [WORD_W-1:0] mean_time;
    logic signed [WORD_W-1:0] half_difference;
    logic [1:0]               status;
  } pmtc_out_t;

  // calibration words of one channel
  typedef struct packed {
    logic signed [WORD_W-1:0] adc_ped;
    logic signed [WORD_W-1:0] adc_gain;
    logic signed [WORD_W-1:0] tdc_ped;
    logic signed [WORD_W-1:0] tdc_sigma;
    logic signed [WORD_W-1:0] tdc_gain;
    logic signed [WORD_W-1:0] slew0;
    logic signed [WORD_W-1:0] slew1;
  } cal_t;

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh000000007FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sh0000000080000000) begin
      return -32'sh80000000;
    end else begin
      return v[WORD_W-1:0];
    end
  endfunction

endpackage

### hw/rtl/pmt_hit_calibrator_unit.sv
// top level of the pmt hit calibrator: tables, two hit pipes, pair combine
// depends on pmtc_pkg, pmtc_table, pmtc_hit and the assertion macro header
//
//  port group     direction  handshake                 payload
//  command        in         start (busy always low)   in_i
//  result         out        done_o, one-cycle strobe  result_o
//  config write   in         cfg_we_i                  cfg_wdata_i
//
// every command yields one result after it is taken, one per cycle
// the latency is set by the 24-step square root and the 48-step slewing divider
// table writes land at the accepting edge; the next command already sees them
// reset clears control and the sigma multiplier (3.0); tables are not cleared
// results cannot be stalled, so the pipeline never stalls either
`include "pmt_hit_calibrator_unit_macros.svh"
module pmt_hit_calibrator_unit #(
  parameter int NUM_CHANNELS = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  pmtc_pkg::pmtc_in_t           in_i,
  input  logic                         cfg_we_i,
  input  logic [pmtc_pkg::SM_W-1:0]    cfg_wdata_i,
  output logic                         done_o,
  output pmtc_pkg::pmtc_out_t          result_o
);
  import pmtc_pkg::*;

  localparam int ADDR_W = $clog2(NUM_CHANNELS);
  localparam logic [CH_W:0] NUM_CH = (CH_W+1)'(NUM_CHANNELS);

  logic accept, a_ok, b_ok, tbl_we;
  logic [1:0] status_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign a_ok   = {1'b0, in_i.channel_a} < NUM_CH;
  assign b_ok   = {1'b0, in_i.channel_b} < NUM_CH;
  assign tbl_we = accept && (in_i.operation == OP_WRITE) && a_ok;

  always_comb begin
    if (in_i.operation == OP_WRITE) begin
      status_d = a_ok ? ST_WRITTEN : ST_RANGE;
    end else begin
      status_d = (a_ok && b_ok) ? ST_CALIBRATED : ST_RANGE;
    end
  end

  // sigma multiplier register
  logic [SM_W-1:0] sigma_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q <= SIGMA_MULT_RST;
    end else if (cfg_we_i) begin
      sigma_q <= cfg_wdata_i;
    end
  end

  cal_t cal_a, cal_b;

  pmtc_table #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .ADDR_W       (ADDR_W)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .kind_i    (in_i.param_kind),
    .waddr_i   (in_i.channel_a[ADDR_W-1:0]),
    .wdata_i   (in_i.param_value),
    .raddr_a_i (in_i.channel_a[ADDR_W-1:0]),
    .raddr_b_i (in_i.channel_b[ADDR_W-1:0]),
    .rdata_a_o (cal_a),
    .rdata_b_o (cal_b)
  );

  // raw counts aligned with the table read data
  logic [ADC_W-1:0] adc_a_q, adc_b_q;
  logic [TDC_W-1:0] tdc_a_q, tdc_b_q;
  always_ff @(posedge clk_i) begin
    adc_a_q <= in_i.adc_a;
    tdc_a_q <= in_i.tdc_a;
    adc_b_q <= in_i.adc_b;
    tdc_b_q <= in_i.tdc_b;
  end

  logic signed [WORD_W-1:0] npe_a, npe_b, time_a, time_b;

  pmtc_hit u_hit_a (
    .clk_i        (clk_i),
    .adc_i        (adc_a_q),
    .tdc_i        (tdc_a_q),
    .cal_i        (cal_a),
    .sigma_mult_i (sigma_q),
    .npe_o        (npe_a),
    .time_o       (time_a)
  );

  pmtc_hit u_hit_b (
    .clk_i        (clk_i),
    .adc_i        (adc_b_q),
    .tdc_i        (tdc_b_q),
    .cal_i        (cal_b),
    .sigma_mult_i (sigma_q),
    .npe_o        (npe_b),
    .time_o       (time_b)
  );

  // valid and status travel beside the hit pipes
  logic       vld_q [HIT_LAT+1];
  logic [1:0] st_q  [HIT_LAT+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= HIT_LAT; k++) begin
        vld_q[k] <= 1'b0;
        st_q[k]  <= ST_CALIBRATED;
      end
    end else begin
      vld_q[0] <= accept;
      st_q[0]  <= status_d;
      for (int k = 1; k <= HIT_LAT; k++) begin
        vld_q[k] <= vld_q[k-1];
        st_q[k]  <= st_q[k-1];
      end
    end
  end

  // pair combine, floor halving by arithmetic shift
  logic signed [WORD_W:0] t_sum, t_dif;
  pmtc_out_t              result_d, result_q;
  logic                   done_q;

  assign t_sum = 33'(time_a) + 33'(time_b);
  assign t_dif = 33'(time_a) - 33'(time_b);

  always_comb begin
    result_d        = '0;
    result_d.status = st_q[HIT_LAT];
    if (st_q[HIT_LAT] == ST_CALIBRATED) begin
      result_d.npe_a           = npe_a;
      result_d.npe_b           = npe_b;
      result_d.time_a          = time_a;
      result_d.time_b          = time_b;
      result_d.mean_time       = t_sum[WORD_W:1];
      result_d.half_difference = t_dif[WORD_W:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[HIT_LAT];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `PMTC_ASSERT_IMP(a_latency, accept, ##UNIT_LAT done_o, "result missing after fixed latency")
  `PMTC_ASSERT_IMP(a_zero_fields, done_o && (result_o.status != ST_CALIBRATED),
    (result_o.npe_a == 0) && (result_o.time_a == 0) && (result_o.mean_time == 0),
    "non-calibration result carries data")
  `PMTC_ASSERT_IMP(a_pair_combine, done_o && (result_o.status == ST_CALIBRATED),
    (result_o.mean_time - result_o.half_difference) == result_o.time_b,
    "mean and half difference disagree with time_b")
  `PMTC_ASSERT_NXT(a_cfg_write, cfg_we_i, sigma_q == $past(cfg_wdata_i),
    "sigma multiplier not updated")

endmodule

### hw/rtl/pmtc_table.sv
// seven per-channel calibration tables, one write port, two registered read ports
// depends on pmtc_pkg
module pmtc_table #(
  parameter int NUM_CHANNELS = 512,
  parameter int ADDR_W       = $clog2(NUM_CHANNELS)
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [2:0]                       kind_i,
  input  logic [ADDR_W-1:0]                waddr_i,
  input  logic signed [pmtc_pkg::WORD_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0]                raddr_a_i,
  input  logic [ADDR_W-1:0]                raddr_b_i,
  output pmtc_pkg::cal_t                   rdata_a_o,
  output pmtc_pkg::cal_t                   rdata_b_o
);
  import pmtc_pkg::*;

  logic signed [WORD_W-1:0] adc_ped_mem   [NUM_CHANNELS];
  logic signed [WORD_W-1:0] adc_gain_mem  [NUM_CHANNELS];
  logic signed [WORD_W-1:0] tdc_ped_mem   [NUM_CHANNELS];
  logic signed [WORD_W-1:0] tdc_sigma_mem [NUM_CHANNELS];
  logic signed [WORD_W-1:0] tdc_gain_mem  [NUM_CHANNELS];
  logic signed [WORD_W-1:0] slew0_mem     [NUM_CHANNELS];
  logic signed [WORD_W-1:0] slew1_mem     [NUM_CHANNELS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      case (kind_i)
        KIND_ADC_PED:   adc_ped_mem[waddr_i]   <= wdata_i;
        KIND_ADC_GAIN:  adc_gain_mem[waddr_i]  <= wdata_i;
        KIND_TDC_PED:   tdc_ped_mem[waddr_i]   <= wdata_i;
        KIND_TDC_SIGMA: tdc_sigma_mem[waddr_i] <= wdata_i;
        KIND_TDC_GAIN:  tdc_gain_mem[waddr_i]  <= wdata_i;
        KIND_SLEW0:     slew0_mem[waddr_i]     <= wdata_i;
        KIND_SLEW1:     slew1_mem[waddr_i]     <= wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o.adc_ped   <= adc_ped_mem[raddr_a_i];
    rdata_a_o.adc_gain  <= adc_gain_mem[raddr_a_i];
    rdata_a_o.tdc_ped   <= tdc_ped_mem[raddr_a_i];
    rdata_a_o.tdc_sigma <= tdc_sigma_mem[raddr_a_i];
    rdata_a_o.tdc_gain  <= tdc_gain_mem[raddr_a_i];
    rdata_a_o.slew0     <= slew0_mem[raddr_a_i];
    rdata_a_o.slew1     <= slew1_mem[raddr_a_i];
    rdata_b_o.adc_ped   <= adc_ped_mem[raddr_b_i];
    rdata_b_o.adc_gain  <= adc_gain_mem[raddr_b_i];
    rdata_b_o.tdc_ped   <= tdc_ped_mem[raddr_b_i];
    rdata_b_o.tdc_sigma <= tdc_sigma_mem[raddr_b_i];
    rdata_b_o.tdc_gain  <= tdc_gain_mem[raddr_b_i];
    rdata_b_o.slew0     <= slew0_mem[raddr_b_i];
    rdata_b_o.slew1     <= slew1_mem[raddr_b_i];
  end

endmodule

### hw/rtl/pmtc_hit.sv
// calibration pipeline of one pmt hit: npe divider, square root, slewing divider
// depends on pmtc_pkg
module pmtc_hit (
  input  logic                               clk_i,
  input  logic [pmtc_pkg::ADC_W-1:0]         adc_i,
  input  logic [pmtc_pkg::TDC_W-1:0]         tdc_i,
  input  pmtc_pkg::cal_t                     cal_i,
  input  logic [pmtc_pkg::SM_W-1:0]          sigma_mult_i,
  output logic signed [pmtc_pkg::WORD_W-1:0] npe_o,
  output logic signed [pmtc_pkg::WORD_W-1:0] time_o
);
  import pmtc_pkg::*;

  // ---------------- stage 1: offsets and products
  logic signed [32:0]       a_q;
  logic signed [WORD_W-1:0] gain_q, tped_q, slew0_q, slew1_q;
  logic signed [48:0]       sig_prod_q;
  logic signed [44:0]       tmul_q;
  logic [TDC_W-1:0]         tdc_q;

  always_ff @(posedge clk_i) begin
    a_q        <= $signed({5'b0, adc_i, 16'b0}) - 33'(cal_i.adc_ped);
    gain_q     <= cal_i.adc_gain;
    tped_q     <= cal_i.tdc_ped;
    slew0_q    <= cal_i.slew0;
    slew1_q    <= cal_i.slew1;
    sig_prod_q <= $signed({1'b0, sigma_mult_i}) * cal_i.tdc_sigma;
    tmul_q     <= $signed({1'b0, tdc_i}) * cal_i.tdc_gain;
    tdc_q      <= tdc_i;
  end

  // ---------------- stage 2/3: threshold and accept flag
  logic signed [49:0] thr_q;
  logic [TDC_W-1:0]   tdc2_q;
  logic               pre_ok_q;
  logic signed [45:0] tsum_q [HIT_LAT-3];
  logic               ok_q   [HIT_LAT-3];

  always_ff @(posedge clk_i) begin
    thr_q     <= 50'(sig_prod_q) + 50'($signed({tped_q, 8'b0}));
    tdc2_q    <= tdc_q;
    pre_ok_q  <= (gain_q < GAIN_LIMIT) && (tdc_q != '0) && (a_q > 0);
    tsum_q[0] <= 46'(tmul_q) + 46'(slew0_q);
    ok_q[0]   <= pre_ok_q && ($signed({14'b0, tdc2_q, 24'b0}) > thr_q);
    for (int k = 1; k < HIT_LAT - 3; k++) begin
      tsum_q[k] <= tsum_q[k-1];
      ok_q[k]   <= ok_q[k-1];
    end
  end

  // ---------------- npe: restoring divider, one quotient bit per stage
  logic [31:0] a_mag, g_mag;
  assign a_mag = a_q[32] ? 32'(-a_q) : a_q[31:0];
  assign g_mag = gain_q[31] ? $unsigned(-gain_q) : $unsigned(gain_q);

  logic [NPE_STEPS-1:0] nd_dvd_q  [NPE_STEPS];
  logic [31:0]          nd_rem_q  [NPE_STEPS];
  logic [31:0]          nd_dvs_q  [NPE_STEPS];
  logic                 nd_neg_q  [NPE_STEPS];
  logic                 nd_zero_q [NPE_STEPS];

  for (genvar i = 0; i < NPE_STEPS; i++) begin : g_npe
    logic [NPE_STEPS-1:0] dvd_in;
    logic [31:0]          rem_in, dvs_in;
    logic                 neg_in, zero_in, fits;
    logic [32:0]          trial;
    if (i == 0) begin : g_first
      assign dvd_in  = {a_mag, 8'b0};
      assign rem_in  = '0;
      assign dvs_in  = g_mag;
      assign neg_in  = a_q[32] ^ gain_q[31];
      assign zero_in = (gain_q == '0);
    end else begin : g_next
      assign dvd_in  = nd_dvd_q[i-1];
      assign rem_in  = nd_rem_q[i-1];
      assign dvs_in  = nd_dvs_q[i-1];
      assign neg_in  = nd_neg_q[i-1];
      assign zero_in = nd_zero_q[i-1];
    end
    assign trial = {rem_in, dvd_in[NPE_STEPS-1]};
    assign fits  = trial >= {1'b0, dvs_in};
    always_ff @(posedge clk_i) begin
      nd_rem_q[i]  <= fits ? 32'(trial - {1'b0, dvs_in}) : trial[31:0];
      nd_dvd_q[i]  <= {dvd_in[NPE_STEPS-2:0], fits};
      nd_dvs_q[i]  <= dvs_in;
      nd_neg_q[i]  <= neg_in;
      nd_zero_q[i] <= zero_in;
    end
  end

  logic signed [NPE_STEPS+1:0] npe_mag, npe_sgn;
  logic signed [WORD_W-1:0]    npe_dly_q [NPE_PAD];
  assign npe_mag = $signed({2'b0, nd_dvd_q[NPE_STEPS-1]});
  assign npe_sgn = nd_neg_q[NPE_STEPS-1] ? -npe_mag : npe_mag;

  logic signed [WORD_W-1:0] npe_q;
  always_ff @(posedge clk_i) begin
    npe_q        <= nd_zero_q[NPE_STEPS-1] ? '0 : sat32(64'(npe_sgn));
    npe_dly_q[0] <= npe_q;
    for (int k = 1; k < NPE_PAD; k++) begin
      npe_dly_q[k] <= npe_dly_q[k-1];
    end
  end
  assign npe_o = npe_dly_q[NPE_PAD-1];

  // ---------------- square root of a * 2^16, two radicand bits per stage
  logic [2*SQ_STEPS-1:0] sq_rad_q  [SQ_STEPS];
  logic [SQ_STEPS-1:0]   sq_root_q [SQ_STEPS];
  logic [SQ_STEPS+1:0]   sq_rem_q  [SQ_STEPS];
  logic [31:0]           sl_mag_q  [SQ_STEPS];
  logic                  sl_neg_q  [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    logic [2*SQ_STEPS-1:0] rad_in;
    logic [SQ_STEPS-1:0]   root_in;
    logic [SQ_STEPS+1:0]   rem_in;
    logic [SQ_STEPS+3:0]   trial;
    logic [SQ_STEPS+1:0]   sub;
    logic                  fits;
    if (i == 0) begin : g_first
      assign rad_in  = (a_q > 0) ? {a_q[31:0], 16'b0} : '0;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign rad_in  = sq_rad_q[i-1];
      assign root_in = sq_root_q[i-1];
      assign rem_in  = sq_rem_q[i-1];
    end
    assign trial = {rem_in, rad_in[2*SQ_STEPS-1 -: 2]};
    assign sub   = {root_in, 2'b01};
    assign fits  = trial >= {2'b0, sub};
    always_ff @(posedge clk_i) begin
      sq_rem_q[i]  <= fits ? (SQ_STEPS+2)'(trial - {2'b0, sub}) : trial[SQ_STEPS+1:0];
      sq_root_q[i] <= {root_in[SQ_STEPS-2:0], fits};
      sq_rad_q[i]  <= {rad_in[2*SQ_STEPS-3:0], 2'b00};
    end
  end

  // slewing scale rides alongside the root
  always_ff @(posedge clk_i) begin
    sl_mag_q[0] <= slew1_q[31] ? $unsigned(-slew1_q) : $unsigned(slew1_q);
    sl_neg_q[0] <= slew1_q[31];
    for (int k = 1; k < SQ_STEPS; k++) begin
      sl_mag_q[k] <= sl_mag_q[k-1];
      sl_neg_q[k] <= sl_neg_q[k-1];
    end
  end

  // ---------------- slew1 * 2^16 / root, one quotient bit per stage
  logic [TDIV_STEPS-1:0] td_dvd_q [TDIV_STEPS];
  logic [SQ_STEPS-1:0]   td_rem_q [TDIV_STEPS];
  logic [SQ_STEPS-1:0]   td_dvs_q [TDIV_STEPS];
  logic                  td_neg_q [TDIV_STEPS];

  for (genvar i = 0; i < TDIV_STEPS; i++) begin : g_tdiv
    logic [TDIV_STEPS-1:0] dvd_in;
    logic [SQ_STEPS-1:0]   rem_in, dvs_in;
    logic                  neg_in, fits;
    logic [SQ_STEPS:0]     trial;
    if (i == 0) begin : g_first
      assign dvd_in = {sl_mag_q[SQ_STEPS-1], 16'b0};
      assign rem_in = '0;
      assign dvs_in = sq_root_q[SQ_STEPS-1];
      assign neg_in = sl_neg_q[SQ_STEPS-1];
    end else begin : g_next
      assign dvd_in = td_dvd_q[i-1];
      assign rem_in = td_rem_q[i-1];
      assign dvs_in = td_dvs_q[i-1];
      assign neg_in = td_neg_q[i-1];
    end
    assign trial = {rem_in, dvd_in[TDIV_STEPS-1]};
    assign fits  = trial >= {1'b0, dvs_in};
    always_ff @(posedge clk_i) begin
      td_rem_q[i] <= fits ? SQ_STEPS'(trial - {1'b0, dvs_in}) : trial[SQ_STEPS-1:0];
      td_dvd_q[i] <= {dvd_in[TDIV_STEPS-2:0], fits};
      td_dvs_q[i] <= dvs_in;
      td_neg_q[i] <= neg_in;
    end
  end

  // ---------------- final sum, rescale to q23.8, reject
  logic signed [49:0] quo_mag, quo_sgn;
  logic signed [49:0] t16_q;
  assign quo_mag = $signed({2'b0, td_dvd_q[TDIV_STEPS-1]});
  assign quo_sgn = td_neg_q[TDIV_STEPS-1] ? -quo_mag : quo_mag;

  always_ff @(posedge clk_i) begin
    t16_q  <= 50'(tsum_q[HIT_LAT-4]) + quo_sgn;
    time_o <= ok_q[HIT_LAT-4] ? sat32(64'(t16_q >>> 8)) : TIME_SENTINEL;
  end

endmodule
